FILE: design/brld_pkg.sv
package brld_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_BLOCK    = 4096;
    localparam int FLOOR_DB_Q8  = -25600;
    localparam int SUM_W        = 42;
    localparam int LEN_W        = 13;
    localparam int CH_W         = 3;
    localparam int SAMPLE_W     = 16;
    localparam int LEVEL_W      = 16;
    localparam int FRAC_BITS    = 16;
    localparam int FIFO_DEPTH   = 2;
    localparam logic [25:0] LOGC = 26'd50504453;

    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
    localparam logic [1:0] REG_NUM_CHANNELS = 2'd1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] len;
        logic [CH_W-1:0]  ch;
    } blk_job_t;

endpackage

FILE: design/brld_front.sv
module brld_front
    import brld_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic signed [SAMPLE_W-1:0] in_sample,
    input  logic [CH_W-1:0]            in_ch,
    input  logic [LEN_W-1:0]           block_length,
    input  logic [3:0]                 num_channels,
    output logic                       push,
    output blk_job_t                   push_job
);

    logic [SUM_W-1:0] sum_reg   [MAX_CHANNELS];
    logic [LEN_W-1:0] count_reg [MAX_CHANNELS];

    logic                 in_use;
    logic [31:0]          square;
    logic [SUM_W:0]       sum_add;
    logic [SUM_W-1:0]     sum_next;
    logic [LEN_W-1:0]     count_next;
    logic [LEN_W-1:0]     len_eff;
    logic                 complete;

    assign in_use = ({1'b0, in_ch} < num_channels);
    assign square = 32'($signed(in_sample) * $signed(in_sample));
    assign sum_add = {1'b0, sum_reg[in_ch]} + {11'd0, square};
    assign sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    assign count_next = (count_reg[in_ch] == {LEN_W{1'b1}}) ? count_reg[in_ch]
                                                          : count_reg[in_ch] + 1'b1;

    always_comb begin
        if (block_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (block_length > LEN_W'(MAX_BLOCK)) begin
            len_eff = LEN_W'(MAX_BLOCK);
        end else begin
            len_eff = block_length;
        end
    end

    assign complete = count_next >= len_eff;
    assign push = in_valid && in_use && complete;
    assign push_job = '{sum: sum_next, len: len_eff, ch: in_ch};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
            end
        end else if (in_valid && in_use) begin
            sum_reg[in_ch]   <= complete ? '0 : sum_next;
            count_reg[in_ch] <= complete ? '0 : count_next;
        end
    end

endmodule

FILE: design/brld_fifo.sv
module brld_fifo
    import brld_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  blk_job_t push_job,
    input  logic     pop,
    output logic     empty,
    output logic     full,
    output blk_job_t head
);

    blk_job_t mem_reg [FIFO_DEPTH];
    logic     wr_ptr_reg;
    logic     rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'(FIFO_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue underflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(FIFO_DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: design/brld_back.sv
module brld_back
    import brld_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      job_avail,
    input  blk_job_t                  job,
    output logic                      pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [LEVEL_W-1:0] m_level,
    output logic [CH_W-1:0]           m_ch
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_NORM, S_SQR, S_MUL, S_ADD, S_OUT
    } state_t;

    localparam logic [21:0] TOP_LG = 22'(30) << FRAC_BITS;

    state_t                    state_reg;
    logic [SUM_W-1:0]          dvd_reg;
    logic [LEN_W:0]            rem_reg;
    logic [LEN_W-1:0]          div_reg;
    logic [5:0]                cnt_reg;
    logic [CH_W-1:0]           ch_reg;
    logic [31:0]               x_reg;
    logic [5:0]                p_reg;
    logic [FRAC_BITS-1:0]      frac_reg;
    logic [46:0]               prod_reg;
    logic signed [LEVEL_W-1:0] level_reg;
    logic                      m_valid_reg;
    logic signed [LEVEL_W-1:0] m_level_reg;
    logic [CH_W-1:0]           m_ch_reg;

    logic [LEN_W:0]   trial;
    logic             qbit;
    logic [LEN_W:0]   rem_next;
    logic [SUM_W-1:0] dvd_next;
    logic [63:0]      sq;
    logic [33:0]      sq_sh;
    logic [21:0]      lg;
    logic [47:0]      rounded;
    logic [15:0]      mag;
    logic [16:0]      mag_c;
    logic signed [17:0] lvl;

    assign trial    = {rem_reg[LEN_W-1:0], dvd_reg[SUM_W-1]};
    assign qbit     = trial >= {1'b0, div_reg};
    assign rem_next = qbit ? trial - {1'b0, div_reg} : trial;
    assign dvd_next = {dvd_reg[SUM_W-2:0], qbit};
    assign sq       = x_reg * x_reg;
    assign sq_sh    = sq[63:30];
    assign lg       = {p_reg[5:0], frac_reg};
    assign rounded  = {1'b0, prod_reg} + 48'h0000_8000_0000;
    assign mag      = rounded[47:32];
    assign mag_c    = ({1'b0, mag} > 17'd32768) ? 17'd32768 : {1'b0, mag};
    assign lvl      = -$signed({1'b0, mag_c});

    assign pop     = (state_reg == S_IDLE) && job_avail;
    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;
    assign m_ch    = m_ch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_OUT) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (job_avail) begin
                        dvd_reg   <= job.sum;
                        div_reg   <= job.len;
                        ch_reg    <= job.ch;
                        rem_reg   <= '0;
                        cnt_reg   <= 6'(SUM_W - 1);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_next;
                    dvd_reg <= dvd_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        p_reg <= 6'(SUM_W - 1);
                        if (dvd_next == '0) begin
                            level_reg <= LEVEL_W'(FLOOR_DB_Q8);
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    // shift left until the top bit is set, tracking its position
                    if (dvd_reg[SUM_W-1]) begin
                        x_reg     <= {1'b0, dvd_reg[SUM_W-1:SUM_W-31]};
                        frac_reg  <= '0;
                        cnt_reg   <= 6'(FRAC_BITS - 1);
                        state_reg <= S_SQR;
                    end else begin
                        dvd_reg <= {dvd_reg[SUM_W-2:0], 1'b0};
                        p_reg   <= p_reg - 1'b1;
                    end
                end
                S_SQR: begin
                    x_reg    <= sq_sh[31] ? sq_sh[32:1] : sq_sh[31:0];
                    frac_reg <= {frac_reg[FRAC_BITS-2:0], sq_sh[31]};
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) state_reg <= S_MUL;
                end
                S_MUL: begin
                    if (lg >= TOP_LG) begin
                        level_reg <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        prod_reg  <= 21'(TOP_LG - lg) * LOGC;
                        state_reg <= S_ADD;
                    end
                end
                S_ADD: begin
                    level_reg <= (lvl < 18'(FLOOR_DB_Q8)) ? LEVEL_W'(FLOOR_DB_Q8)
                                                          : lvl[LEVEL_W-1:0];
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_level_reg <= level_reg;
                        m_ch_reg    <= ch_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_level_reg <= 0 && m_level_reg >= LEVEL_W'(FLOOR_DB_Q8)))
        else $error("level out of range");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg == S_DIV) else $error("job not started");
    a_norm_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_NORM |-> dvd_reg != '0) else $error("normalizing zero");
`endif

endmodule

FILE: design/block_rms_level_db_core.sv
// Per-channel block RMS meter: each accepted word on an enabled channel adds the
// square of its sample to its channel's sum; when a channel reaches block_length
// samples, 20*log10(RMS) is produced in 1/256 dB (floored at -100 dB, 0 dB at full
// scale) and the channel restarts. Samples are taken one per cycle. Each finished
// block is then worked out by a shared back end in pickup, divide, normalize,
// squaring, multiply, add and output steps; a two-entry queue lets the front run
// on while the back end works, and stalls input only when two blocks are waiting.
module block_rms_level_db_core
    import brld_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // sample
    input  logic [2:0]            s_tuser,   // channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // level_db
    output logic [2:0]            m_tuser,   // out_channel
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [LEN_W-1:0]      cfg_data
);

    logic [LEN_W-1:0] block_length_reg;
    logic [3:0]       num_channels_reg;
    logic             push;
    blk_job_t         push_job;
    logic             empty;
    logic             full;
    blk_job_t         head;
    logic             pop;
    logic signed [LEVEL_W-1:0] level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_length_reg <= LEN_W'(1024);
            num_channels_reg <= 4'd1;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BLOCK_LENGTH: block_length_reg <= cfg_data;
                REG_NUM_CHANNELS: num_channels_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !full;

    brld_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid && s_tready),
        .in_sample    (s_tdata),
        .in_ch        (s_tuser),
        .block_length (block_length_reg),
        .num_channels (num_channels_reg),
        .push         (push),
        .push_job     (push_job)
    );

    brld_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .empty    (empty),
        .full     (full),
        .head     (head)
    );

    brld_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_avail (!empty),
        .job       (head),
        .pop       (pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_level   (level),
        .m_ch      (m_tuser)
    );

    assign m_tdata = level;

endmodule

FILE: verif/block_rms_level_db_core_tb.sv
`timescale 1ns / 1ps

module block_rms_level_db_core_tb;
    import brld_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 300;

    typedef enum logic [1:0] {CHK_PRED, CHK_FIXED} chk_kind_t;

    typedef struct {
        logic signed [15:0] level;
        logic [2:0]         ch;
    } level_t;

    typedef struct {
        logic [15:0]        sample;
        logic [2:0]         ch;
        chk_kind_t          kind;
        logic signed [15:0] level;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;   // sample
    logic [2:0] s_tuser = '0;    // channel
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;        // level_db
    logic [2:0] m_tuser;         // out_channel
    logic cfg_we = 1'b0;
    logic [1:0] cfg_addr = REG_BLOCK_LENGTH;
    logic [LEN_W-1:0] cfg_data = '0;

    // shadow of the meter
    logic [SUM_W-1:0] acc_sum [MAX_CHANNELS];
    logic [LEN_W-1:0] acc_cnt [MAX_CHANNELS];
    logic [LEN_W-1:0] blk_len = 13'd1024;
    logic [3:0] chan_cnt = 4'd1;

    level_t pending_levels[$];
    int fails = 0;
    int cyc = 0;
    int src_pct = 0;
    int snk_pct = 0;

    block_rms_level_db_core i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_we, .cfg_addr, .cfg_data
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge aclk) m_tready = ($urandom_range(99) >= snk_pct);

    function automatic logic [31:0] log2_q16(logic [63:0] v);
        logic [31:0] p;
        logic [63:0] x;
        logic [63:0] t;
        logic [31:0] frac;
        p = 0;
        frac = 0;
        t = v;
        while (t > 1) begin
            t = t >> 1;
            p++;
        end
        x = (p <= 30) ? v << (30 - p) : v >> (p - 30);
        for (int i = 0; i < FRAC_BITS; i++) begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= 64'd1 << 31) begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return (p << FRAC_BITS) | frac;
    endfunction

    function automatic logic signed [15:0] db_of_mean(logic [63:0] mean);
        logic [31:0] lg;
        logic [31:0] top;
        logic [63:0] mag;
        int lvl;
        top = 32'd30 << FRAC_BITS;
        if (mean == 0) return 16'(FLOOR_DB_Q8);
        lg = log2_q16(mean);
        if (lg >= top) return 16'sd0;
        mag = (64'(top - lg) * 64'(LOGC) + (64'd1 << 31)) >> 32;
        if (mag > 32768) mag = 32768;
        lvl = -int'(mag);
        if (lvl < FLOOR_DB_Q8) lvl = FLOOR_DB_Q8;
        return 16'(lvl);
    endfunction

    // updates the shadow; returns 1 when the word completes a block
    function automatic bit meter_word(logic [15:0] sample, logic [2:0] ch,
                                      output logic signed [15:0] level);
        logic signed [31:0] s;
        logic [63:0] sum;
        logic [63:0] len;
        s = $signed(sample);
        level = '0;
        if (ch >= chan_cnt) return 0;
        sum = 64'(acc_sum[ch]) + 64'(s * s);
        acc_sum[ch] = (sum > {SUM_W{1'b1}}) ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
        if (acc_cnt[ch] != 13'h1FFF) acc_cnt[ch]++;
        len = (blk_len == 0) ? 1 : (blk_len > MAX_BLOCK) ? MAX_BLOCK : blk_len;
        if (acc_cnt[ch] < len) return 0;
        level = db_of_mean(64'(acc_sum[ch]) / len);
        acc_sum[ch] = '0;
        acc_cnt[ch] = '0;
        return 1;
    endfunction

    task automatic send_word(logic [15:0] sample, logic [2:0] ch, chk_kind_t kind,
                             logic signed [15:0] fixed_level);
        logic signed [15:0] lvl;
        while ($urandom_range(99) < src_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = sample;
        s_tuser = ch;
        do @(posedge aclk); while (!s_tready);
        if (meter_word(sample, ch, lvl))
            pending_levels.push_back('{kind == CHK_FIXED ? fixed_level : lvl, ch});
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_levels.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [LEN_W-1:0] val);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_BLOCK_LENGTH) blk_len = val;
        else if (idx == REG_NUM_CHANNELS) chan_cnt = val[3:0];
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'($signed(12'($urandom)));
            2: return 16'($signed(5'($urandom)));
            3: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        level_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                $error("result with none expected: level_db %0d out_channel %0d",
                       $signed(m_tdata), m_tuser);
                fails++;
            end else begin
                want = pending_levels.pop_front();
                if (m_tdata !== want.level) begin
                    $error("level_db expected %0d actual %0d", want.level, $signed(m_tdata));
                    fails++;
                end
                if (m_tuser !== want.ch) begin
                    $error("out_channel expected %0d actual %0d", want.ch, m_tuser);
                    fails++;
                end
            end
        end
    end

    stim_row_t directed[] = '{
        '{16'h0000, 3'd0, CHK_FIXED, 16'(FLOOR_DB_Q8)},
        '{16'h8000, 3'd1, CHK_FIXED, 16'sd0},
        '{16'h7FFF, 3'd2, CHK_PRED,  16'sd0},
        '{16'h0001, 3'd3, CHK_PRED,  16'sd0},
        '{16'hFFFF, 3'd0, CHK_PRED,  16'sd0},
        '{16'h1234, 3'd4, CHK_PRED,  16'sd0},
        '{16'h7FFF, 3'd7, CHK_PRED,  16'sd0},
        '{16'h5555, 3'd1, CHK_PRED,  16'sd0},
        '{16'hAAAA, 3'd2, CHK_PRED,  16'sd0},
        '{16'h4000, 3'd3, CHK_PRED,  16'sd0},
        '{16'hC000, 3'd0, CHK_PRED,  16'sd0},
        '{16'h0100, 3'd1, CHK_PRED,  16'sd0},
        '{16'h0008, 3'd2, CHK_PRED,  16'sd0},
        '{16'h8001, 3'd3, CHK_PRED,  16'sd0},
        '{16'h0000, 3'd5, CHK_PRED,  16'sd0},
        '{16'h0000, 3'd6, CHK_PRED,  16'sd0},
        '{16'h0000, 3'd3, CHK_FIXED, 16'(FLOOR_DB_Q8)},
        '{16'h8000, 3'd2, CHK_FIXED, 16'sd0}
    };

    initial begin
        int n;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            acc_sum[i] = '0;
            acc_cnt[i] = '0;
        end
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        write_reg(REG_BLOCK_LENGTH, 13'd1);
        write_reg(REG_NUM_CHANNELS, 13'd4);
        foreach (directed[i])
            send_word(directed[i].sample, directed[i].ch, directed[i].kind, directed[i].level);
        drain();

        // zero block length behaves as one
        write_reg(REG_BLOCK_LENGTH, 13'd0);
        write_reg(REG_NUM_CHANNELS, 13'd8);
        for (int i = 0; i < 40; i++) send_word(rand_sample(), 3'($urandom), CHK_PRED, 0);
        drain();

        // oversize length: a long full-scale run stays open until the length drops
        write_reg(REG_BLOCK_LENGTH, 13'h1FFF);
        write_reg(REG_NUM_CHANNELS, 13'd1);
        for (int i = 0; i < 200; i++) send_word(16'h8000, 3'd0, CHK_PRED, 0);
        drain();

        // length lowered mid-block
        write_reg(REG_BLOCK_LENGTH, 13'd16);
        write_reg(REG_NUM_CHANNELS, 13'd2);
        for (int i = 0; i < 10; i++) send_word(rand_sample(), 3'd0, CHK_PRED, 0);
        for (int i = 0; i < 3; i++) send_word(rand_sample(), 3'd1, CHK_PRED, 0);
        drain();
        write_reg(REG_BLOCK_LENGTH, 13'd4);
        send_word(16'h7FFF, 3'd0, CHK_PRED, 0);
        send_word(16'h8000, 3'd1, CHK_PRED, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin src_pct = 35; snk_pct = 78; end
                1: begin src_pct = 78; snk_pct = 35; end
                default: begin src_pct = 0; snk_pct = 0; end
            endcase
            n = (ph == 5) ? 2 : ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 8);
            write_reg(REG_BLOCK_LENGTH, LEN_W'(n));
            write_reg(REG_NUM_CHANNELS, (ph == 5) ? 13'd8 : LEN_W'($urandom_range(1, 8)));
            for (int i = 0; i < 270; i++)
                send_word(rand_sample(),
                          ($urandom_range(9) == 0) ? 3'($urandom)
                                                   : 3'($urandom_range(chan_cnt - 1)),
                          CHK_PRED, 0);
            drain();
        end

        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
